/* hdl/swm_pkg.sv */
// Shared types and constants for the sliding window maximum block.
package swm_pkg;

    // Width of the window_size configuration register.
    localparam int WINDOW_SIZE_BITS = 7;

    // Per-cycle operation applied to every cell of the candidate chain.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_STEP  = 2'd1,
        CELL_SHIFT = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     first;
    } cell_ctrl_t;

endpackage

/* hdl/swm_cell.sv */
// One candidate cell of the monotonic queue: value, age and valid flag.
module swm_cell import swm_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_W       = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctrl_t             ctrl,
    input  logic                   pop,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   nb_valid,
    input  logic [SAMPLE_BITS-1:0] nb_value,
    input  logic [AGE_W-1:0]       nb_age,
    input  logic                   left_kept,
    output logic                   kept,
    output logic                   valid,
    output logic [SAMPLE_BITS-1:0] value,
    output logic [AGE_W-1:0]       age
);

    logic                   valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0] value_reg, value_next;
    logic [AGE_W-1:0]       age_reg, age_next;
    logic                   src_valid;
    logic [SAMPLE_BITS-1:0] src_value;
    logic [AGE_W-1:0]       src_age;

    // Take the right neighbor's entry when the front entry leaves this step.
    assign src_valid = pop ? nb_valid : valid_reg;
    assign src_value = pop ? nb_value : value_reg;
    assign src_age   = pop ? nb_age   : age_reg;

    // Keep an entry that the new sample does not exceed.
    assign kept = src_valid && !ctrl.first && ($signed(src_value) >= $signed(sample));

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        case (ctrl.op)
            CELL_STEP: begin
                if (kept) begin
                    valid_next = 1'b1;
                    value_next = src_value;
                    age_next   = src_age + AGE_W'(1);
                end else if (left_kept) begin
                    valid_next = 1'b1;
                    value_next = sample;
                    age_next   = '0;
                end else begin
                    valid_next = 1'b0;
                end
            end
            CELL_SHIFT: begin
                valid_next = nb_valid;
                value_next = nb_value;
                age_next   = nb_age;
            end
            default: begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

/* hdl/sliding_window_maximum.sv */
// Top level of the sliding window maximum block built on a chain of candidate cells.
//
//  Channel   Direction  Handshake         Payload
//  s_        in         s_tvalid/tready   tdata: sample; tuser: first
//  m_        out        m_tvalid/tready   tdata: window_max
//  cfg_      in         cfg_we            cfg_wdata: window_size
//
//  One request is taken per cycle while s_tready is high; its result (if any) is valid on the next cycle.
//  After the window is shortened, stale entries leave the chain front one per cycle
//  while no result is waiting, before the next request is taken.
//  Reset clears the cell valid bits, the sample count and the result flag, and sets
//  the window to one; no clearing pass is needed.
//  A waiting result stalls the input only while m_tready is low.
module sliding_window_maximum import swm_pkg::*; #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // window_size
    input  logic                                cfg_we,
    input  logic [WINDOW_SIZE_BITS-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // bits up from 0: sample, zero fill
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    // bit 0: first
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bits up from 0: window_max, zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AGE_W   = $clog2(MAX_WINDOW);
    localparam int WIN_W   = $clog2(MAX_WINDOW + 1);

    logic [WINDOW_SIZE_BITS-1:0] window_size_reg;
    logic [WIN_W-1:0]            seen_reg, seen_next;
    logic                        m_valid_reg, m_valid_next;

    logic [WIN_W-1:0]            win_eff;
    logic [WIN_W-1:0]            seen_base;
    logic [WIN_W-1:0]            seen_inc;
    logic                        drain;
    logic                        pop;
    logic                        accept;
    logic                        emit;
    logic [SAMPLE_BITS-1:0]      sample;
    cell_ctrl_t                  ctrl;

    // Chain arrays; the entry past the last cell is an empty neighbor.
    logic                        cell_valid [0:MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]      cell_value [0:MAX_WINDOW];
    logic [AGE_W-1:0]            cell_age   [0:MAX_WINDOW];
    logic                        kept_chain [0:MAX_WINDOW];

    // Clamp the configured window into one .. MAX_WINDOW.
    always_comb begin
        if (window_size_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (int'(window_size_reg) > MAX_WINDOW) begin
            win_eff = WIN_W'(MAX_WINDOW);
        end else begin
            win_eff = WIN_W'(window_size_reg);
        end
    end

    assign sample = s_tdata[SAMPLE_BITS-1:0];

    // Front entry older than a freshly shortened window: drop it before new requests.
    assign drain = cell_valid[0] && (WIN_W'(cell_age[0]) >= win_eff);
    // Front entry reaches the window edge with this request.
    assign pop   = cell_valid[0] && ((WIN_W'(cell_age[0]) + WIN_W'(1)) >= win_eff);

    assign s_tready = !drain && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ctrl.first = s_tuser[0];
        if (accept) begin
            ctrl.op = CELL_STEP;
        end else if (drain && !m_valid_reg) begin
            ctrl.op = CELL_SHIFT;
        end else begin
            ctrl.op = CELL_HOLD;
        end
    end

    // Sample count: restart on first, hold at the window length.
    always_comb begin
        if (s_tuser[0]) begin
            seen_base = '0;
        end else if (seen_reg > win_eff) begin
            seen_base = win_eff;
        end else begin
            seen_base = seen_reg;
        end
        seen_inc  = (seen_base < win_eff) ? (seen_base + WIN_W'(1)) : seen_base;
        emit      = (seen_inc >= win_eff);
        seen_next = accept ? seen_inc : seen_reg;
    end

    always_comb begin
        if (accept) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WINDOW_SIZE_BITS'(1);
            seen_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_size_reg <= cfg_wdata;
            end
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The front always accepts a newcomer behind nothing.
    assign kept_chain[0]             = 1'b1;
    assign cell_valid[MAX_WINDOW]    = 1'b0;
    assign cell_value[MAX_WINDOW]    = '0;
    assign cell_age[MAX_WINDOW]      = '0;

    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AGE_W       (AGE_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .pop       (pop),
            .sample    (sample),
            .nb_valid  (cell_valid[i+1]),
            .nb_value  (cell_value[i+1]),
            .nb_age    (cell_age[i+1]),
            .left_kept (kept_chain[i]),
            .kept      (kept_chain[i+1]),
            .valid     (cell_valid[i]),
            .value     (cell_value[i]),
            .age       (cell_age[i])
        );
    end

    // The front cell holds the window maximum; it moves on a taken request or a drain shift.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(cell_value[0]);

endmodule
